### src/mf3_pkg.sv
package mf3_pkg;

	// Image geometry.
	localparam int WIDTH  = 128;
	localparam int HEIGHT = 128;

	// Counter widths. The row counter also holds HEIGHT, the drain row.
	localparam int COL_W = $clog2(WIDTH);
	localparam int ROW_W = $clog2(HEIGHT + 1);

	// Pixel and reported position widths.
	localparam int PIX_W = 8;
	localparam int POS_W = 7;

	typedef logic [PIX_W-1:0] pix_t;

	// Nine window pixels. Entries 0..2 are the oldest column (top, middle, bottom)
	// and entries 6..8 are the newest one.
	typedef pix_t [8:0] win_t;

	// One line store word: the pixel two rows up and the pixel one row up.
	typedef struct packed {
		pix_t above;
		pix_t middle;
	} line_word_t;

	// A window that produces results, with the position of its center.
	typedef struct packed {
		win_t              win;
		logic              two;
		logic [POS_W-1:0]  row;
		logic [POS_W-1:0]  col;
	} emit_t;

endpackage

### src/mf3_line_ram.sv
module mf3_line_ram
	import mf3_pkg::*;
(
	input  logic             clk,
	input  logic             rd_en,
	input  logic [COL_W-1:0] rd_addr,
	output line_word_t       rd_data,
	input  logic             wr_en,
	input  logic [COL_W-1:0] wr_addr,
	input  line_word_t       wr_data
);

	line_word_t line_mem_q [WIDTH];
	line_word_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem_q[wr_addr] <= wr_data;
		end
	end

	// Read data holds until the next read, so a stalled consumer keeps its word.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= line_mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### src/mf3_median_out.sv
module mf3_median_out
	import mf3_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             em_valid,
	output logic             em_ready,
	input  emit_t            em,
	output logic [PIX_W-1:0] median,
	output logic [POS_W-1:0] out_row,
	output logic [POS_W-1:0] out_col,
	output logic             last_of_run,
	output logic             out_valid,
	input  logic             out_ready
);

	function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
		pix_t m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
		pix_t m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	function automatic pix_t mid3(input pix_t a, input pix_t b, input pix_t c);
		pix_t lo;
		pix_t hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		return (c < lo) ? lo : ((c > hi) ? hi : c);
	endfunction

	// Sort each group of three ascending.
	function automatic win_t sort_rows(input win_t w);
		win_t s;
		for (int g = 0; g < 3; g++) begin
			s[3*g]     = min3(w[3*g], w[3*g+1], w[3*g+2]);
			s[3*g + 1] = mid3(w[3*g], w[3*g+1], w[3*g+2]);
			s[3*g + 2] = max3(w[3*g], w[3*g+1], w[3*g+2]);
		end
		return s;
	endfunction

	// The three entries of the anti-diagonal once the groups and then the rows are sorted.
	function automatic pix_t [2:0] diag_pick(input win_t s);
		pix_t [2:0] d;
		d[0] = min3(s[2], s[5], s[8]);
		d[1] = mid3(s[1], s[4], s[7]);
		d[2] = max3(s[0], s[3], s[6]);
		return d;
	endfunction

	// Stage 1: groups sorted, for the window itself and for the window
	// shifted once more with a zero column (second result of a row end).
	logic             valid_s1;
	win_t             rows0_s1;
	win_t             rows1_s1;
	logic             two_s1;
	logic [POS_W-1:0] row_s1;
	logic [POS_W-1:0] col_s1;

	// Stage 2: anti-diagonal candidates.
	logic             valid_s2;
	pix_t [2:0]       diag0_s2;
	pix_t [2:0]       diag1_s2;
	logic             two_s2;
	logic [POS_W-1:0] row_s2;
	logic [POS_W-1:0] col_s2;

	// Stage 3: output register holding one or two medians.
	logic             valid_s3;
	pix_t             med0_s3;
	pix_t             med1_s3;
	logic             two_s3;
	logic [POS_W-1:0] row_s3;
	logic [POS_W-1:0] col_s3;
	logic             second_q;

	logic take_s1;
	logic take_s2;
	logic take_s3;
	logic out_xfer;
	logic out_done;
	win_t win_zero_shift;

	assign out_xfer = out_valid && out_ready;
	assign out_done = out_xfer && last_of_run;
	assign take_s3  = !valid_s3 || out_done;
	assign take_s2  = !valid_s2 || take_s3;
	assign take_s1  = !valid_s1 || take_s2;
	assign em_ready = take_s1;

	always_comb begin
		win_zero_shift[5:0] = em.win[8:3];
		win_zero_shift[8:6] = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (take_s1) begin
				valid_s1 <= em_valid;
			end
			if (take_s2) begin
				valid_s2 <= valid_s1;
			end
			if (take_s3) begin
				valid_s3 <= valid_s2;
				second_q <= 1'b0;
			end else if (out_xfer) begin
				second_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && em_valid) begin
			rows0_s1 <= sort_rows(em.win);
			rows1_s1 <= sort_rows(win_zero_shift);
			two_s1   <= em.two;
			row_s1   <= em.row;
			col_s1   <= em.col;
		end
		if (take_s2 && valid_s1) begin
			diag0_s2 <= diag_pick(rows0_s1);
			diag1_s2 <= diag_pick(rows1_s1);
			two_s2   <= two_s1;
			row_s2   <= row_s1;
			col_s2   <= col_s1;
		end
		if (take_s3 && valid_s2) begin
			med0_s3 <= mid3(diag0_s2[0], diag0_s2[1], diag0_s2[2]);
			med1_s3 <= mid3(diag1_s2[0], diag1_s2[1], diag1_s2[2]);
			two_s3  <= two_s2;
			row_s3  <= row_s2;
			col_s3  <= col_s2;
		end
	end

	assign out_valid   = valid_s3;
	assign median      = second_q ? med1_s3 : med0_s3;
	assign out_row     = row_s3;
	assign out_col     = second_q ? POS_W'(WIDTH - 1) : col_s3;
	assign last_of_run = !two_s3 || second_q;

endmodule

### src/median_filter_3x3_stream_core.sv
// Streaming 3x3 median filter for 8-bit pixels of a WIDTH by HEIGHT image in
// raster order, with neighbors outside the image taken as zero. A pixel at row r
// and column c, both at least 1, yields the median centered at (r-1, c-1); a
// pixel in the last column also yields the median centered at (r-1, WIDTH-1),
// and that second result carries last_of_run. After the HEIGHT image rows, send
// one row of WIDTH items with flush set (any item of that row counts as zero) to
// drain the last image row; the position then wraps and a new frame begins.
// The block takes one pixel per clock while the output keeps up. The output
// register holds one input item's results, so the two results at the end of a
// row take two output transfers. The first pixel of every row yields no result,
// and the gap it leaves in the median pipeline absorbs that extra transfer. When
// the output is always ready the input is never held back. A result passes
// stage 1 of the core, then the sorting, candidate and output stages of the
// median block, before it is offered. Both line stores share one memory of WIDTH
// words, read once and written once per cycle at most; it needs no clearing
// after reset.
module median_filter_3x3_stream_core
	import mf3_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [PIX_W-1:0] pixel,
	input  logic             flush,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PIX_W-1:0] median,
	output logic [POS_W-1:0] out_row,
	output logic [POS_W-1:0] out_col,
	output logic             last_of_run
);

	localparam logic [COL_W-1:0] LAST_COL = COL_W'(WIDTH - 1);
	localparam logic [ROW_W-1:0] DRAIN_ROW = ROW_W'(HEIGHT);

	// Raster position of the next pixel to be accepted.
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	// Stage 1: the accepted pixel waits here for its line store word.
	logic             valid_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	pix_t             pix_s1;

	// Sliding window, advanced once per pixel leaving stage 1.
	win_t win_q;
	win_t win_base;
	win_t win_next;

	logic       in_xfer;
	logic       emits_s1;
	logic       adv_s1;
	logic       em_valid;
	logic       em_ready;
	emit_t      em;
	line_word_t rd_word;
	line_word_t wr_word;
	pix_t       top_pix;
	pix_t       mid_pix;

	assign in_xfer  = in_valid && in_ready;
	assign emits_s1 = (row_s1 != '0) && (col_s1 != '0);
	assign em_valid = valid_s1 && emits_s1;
	assign adv_s1   = valid_s1 && (!emits_s1 || em_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
			win_q    <= '0;
		end else begin
			if (in_xfer) begin
				if (col_q == LAST_COL) begin
					col_q <= '0;
					row_q <= (row_q == DRAIN_ROW) ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
			if (in_ready) begin
				valid_s1 <= in_xfer;
			end
			if (adv_s1) begin
				win_q <= win_next;
			end
		end
	end

	// Flushed pixels and every pixel of the drain row enter as zero.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			col_s1 <= col_q;
			row_s1 <= row_q;
			pix_s1 <= (flush || row_q == DRAIN_ROW) ? '0 : pixel;
		end
	end

	// The line store word for a column is read when its pixel is accepted and
	// written back as the pixel leaves stage 1. The next access to the same
	// column comes a full row later, so read and write never collide.
	mf3_line_ram u_line_ram (
		.clk     (clk),
		.rd_en   (in_xfer),
		.rd_addr (col_q),
		.rd_data (rd_word),
		.wr_en   (adv_s1),
		.wr_addr (col_s1),
		.wr_data (wr_word)
	);

	assign wr_word.above  = rd_word.middle;
	assign wr_word.middle = pix_s1;

	// Rows above the image are zero; stale words from earlier frames are masked.
	assign top_pix = (row_s1 >= ROW_W'(2)) ? rd_word.above : '0;
	assign mid_pix = (row_s1 >= ROW_W'(1)) ? rd_word.middle : '0;

	// The first column of a row starts from an all-zero window.
	always_comb begin
		win_base    = (col_s1 == '0) ? '0 : win_q;
		win_next    = win_base;
		win_next[5:0] = win_base[8:3];
		win_next[6] = top_pix;
		win_next[7] = mid_pix;
		win_next[8] = pix_s1;
	end

	always_comb begin
		em.win = win_next;
		em.two = (col_s1 == LAST_COL);
		em.row = POS_W'(row_s1 - ROW_W'(1));
		em.col = POS_W'(col_s1 - COL_W'(1));
	end

	mf3_median_out u_median_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.em_valid    (em_valid),
		.em_ready    (em_ready),
		.em          (em),
		.median      (median),
		.out_row     (out_row),
		.out_col     (out_col),
		.last_of_run (last_of_run),
		.out_valid   (out_valid),
		.out_ready   (out_ready)
	);

	// The line store never sees a read and a write of the same column together.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && adv_s1) |-> (col_q != col_s1))
		else $error("line store read and write hit the same column");

	// After the last drain item the position returns to the frame origin.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && col_q == LAST_COL && row_q == DRAIN_ROW) |=>
		(col_q == '0 && row_q == '0))
		else $error("position did not wrap at end of frame");

	// A result without last_of_run is followed by the row-end result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_of_run) |=>
		(out_valid && last_of_run && out_col == POS_W'(WIDTH - 1)))
		else $error("row-end second result missing");

	// Stage 1 only holds a pixel while it waits for the median pipeline.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |-> (emits_s1 && !em_ready))
		else $error("stage 1 stalled without back-pressure");

endmodule
